// ----- rtl/mep_pkg.sv -----
// ----------------------------------------------------------------------------
// mep_pkg: shared types and constants for the Mandelbrot escape pixel block
// Payload structs, configuration layout, controller commands and status,
// fixed-point widths and the channel palette.
// ----------------------------------------------------------------------------
package mep_pkg;

  // Fixed-point and field widths
  localparam int FRAC_BITS   = 28;                      // Q4.28 coordinates
  localparam int COORD_W     = 32;
  localparam int PIX_W       = 12;
  localparam int SIZE_W      = 13;
  localparam int ITER_W      = 10;
  localparam int PAL_W       = 4;
  localparam int CHAN_W      = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int DIVIDEND_W  = COORD_W + PIX_W;         // |span| * pixel
  localparam int PROD_W      = 2 * COORD_W;             // full square
  localparam int ESC_LIMIT   = 4;
  localparam int PAL_ENTRIES = 10;

  // Shade constants; divisors are SHADE_TOP minus one of the A/B/C shades
  localparam int SHADE_A   = 70;
  localparam int SHADE_B   = 80;
  localparam int SHADE_C   = 90;
  localparam int SHADE_TOP = 100;
  localparam int CHAN_MAX  = 255;
  localparam int SHADE_D10 = SHADE_TOP - SHADE_C;
  localparam int SHADE_D20 = SHADE_TOP - SHADE_B;
  localparam int SHADE_D30 = SHADE_TOP - SHADE_A;
  // 255 is a multiple of 5 and 15, so n*255/d reduces to n*k >> s exactly
  localparam int K_D10 = CHAN_MAX / (SHADE_D10 / 2);    // 51, shift 1
  localparam int K_D20 = CHAN_MAX / (SHADE_D20 / 4);    // 51, shift 2
  localparam int K_D30 = CHAN_MAX / (SHADE_D30 / 2);    // 17, shift 1

  // Reset values of the configuration registers
  localparam logic signed [COORD_W-1:0] RST_LEFT_RE   = -32'sd483183821;
  localparam logic signed [COORD_W-1:0] RST_RIGHT_RE  = 32'sd134217728;
  localparam logic signed [COORD_W-1:0] RST_TOP_IM    = -32'sd322122547;
  localparam logic signed [COORD_W-1:0] RST_BOTTOM_IM = 32'sd322122547;
  localparam logic [SIZE_W-1:0]         RST_WIDTH     = 13'd1024;
  localparam logic [SIZE_W-1:0]         RST_HEIGHT    = 13'd768;
  localparam logic [ITER_W-1:0]         RST_MAX_ITER  = 10'd100;
  localparam logic [PAL_W-1:0]          RST_PALETTE   = 4'd0;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT_RE      = 3'd0,
    CFG_RIGHT_RE     = 3'd1,
    CFG_TOP_IM       = 3'd2,
    CFG_BOTTOM_IM    = 3'd3,
    CFG_IMAGE_WIDTH  = 3'd4,
    CFG_IMAGE_HEIGHT = 3'd5,
    CFG_MAX_ITER     = 3'd6,
    CFG_PALETTE      = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] left_re;
    logic signed [COORD_W-1:0] right_re;
    logic signed [COORD_W-1:0] top_im;
    logic signed [COORD_W-1:0] bottom_im;
    logic [SIZE_W-1:0]         image_width;
    logic [SIZE_W-1:0]         image_height;
    logic [ITER_W-1:0]         max_iter;
    logic [PAL_W-1:0]          palette;
  } cfg_t;

  // Request payload
  typedef struct packed {
    logic [PIX_W-1:0] pixel_col;
    logic [PIX_W-1:0] pixel_row;
  } coord_t;

  // Result payload
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [ITER_W-1:0] iter_count;
    logic              in_set;
  } color_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;    // latch pixel, clear step count
    logic map_diff;   // form |span| and its sign
    logic map_mul;    // span * pixel into the divider
    logic map_fix;    // floor, offset, saturate, store c and z
    logic iter_mul;   // square and cross products of z
    logic iter_upd;   // escape test and next z
    logic out_load;   // load the result register
    logic axis;       // 0: real axis, 1: imaginary axis
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;
    logic limit_zero;
    logic iter_stop;
  } status_t;

  // Channel divisor selection
  typedef enum logic [1:0] {
    SEL_D10 = 2'd0,
    SEL_D20 = 2'd1,
    SEL_D30 = 2'd2
  } div_sel_t;

  typedef struct packed {
    div_sel_t r;
    div_sel_t g;
    div_sel_t b;
  } pal_entry_t;

  // Palette: divisor per channel
  function automatic pal_entry_t pal_lookup(input logic [PAL_W-1:0] pal);
    pal_entry_t e;
    unique case (pal)
      4'd0:    e = '{SEL_D10, SEL_D20, SEL_D30};
      4'd1:    e = '{SEL_D10, SEL_D30, SEL_D20};
      4'd2:    e = '{SEL_D20, SEL_D10, SEL_D30};
      4'd3:    e = '{SEL_D30, SEL_D10, SEL_D20};
      4'd4:    e = '{SEL_D30, SEL_D20, SEL_D10};
      4'd5:    e = '{SEL_D20, SEL_D30, SEL_D10};
      4'd6:    e = '{SEL_D20, SEL_D30, SEL_D20};
      4'd7:    e = '{SEL_D30, SEL_D20, SEL_D20};
      4'd8:    e = '{SEL_D20, SEL_D20, SEL_D30};
      4'd9:    e = '{SEL_D30, SEL_D30, SEL_D10};
      default: e = '{SEL_D10, SEL_D10, SEL_D10};
    endcase
    return e;
  endfunction

  // floor(n * 255 / d) mod 256
  function automatic logic [CHAN_W-1:0] shade(input logic [ITER_W-1:0] n,
                                              input div_sel_t sel);
    logic [ITER_W+5:0] p51;
    logic [ITER_W+4:0] p17;
    logic [CHAN_W-1:0] v;
    p51 = (ITER_W+6)'(n) * (ITER_W+6)'(K_D10);
    p17 = (ITER_W+5)'(n) * (ITER_W+5)'(K_D30);
    unique case (sel)
      SEL_D10: v = CHAN_W'(p51 >> 1);
      SEL_D20: v = CHAN_W'(p51 >> 2);
      SEL_D30: v = CHAN_W'(p17 >> 1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/mep_div.sv -----
// ----------------------------------------------------------------------------
// mep_div: restoring unsigned divider
// One quotient bit per cycle; quotient and a nonzero-remainder flag are held
// after the run for the floor correction.
// ----------------------------------------------------------------------------
module mep_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [mep_pkg::DIVIDEND_W-1:0]    dividend,
  input  logic [mep_pkg::SIZE_W-1:0]        divisor,
  output logic                              done,
  output logic [mep_pkg::DIVIDEND_W-1:0]    quotient,
  output logic                              rem_nz
);

  localparam int DW    = mep_pkg::DIVIDEND_W;
  localparam int VW    = mep_pkg::SIZE_W;
  localparam int CNT_W = $clog2(DW);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    work;
  logic [VW-1:0]    rem;
  logic [VW-1:0]    dvs;
  logic [VW:0]      rem_sh;
  logic             fits;

  // one shift-subtract step
  assign rem_sh = {rem, work[DW-1]};
  assign fits   = (rem_sh >= {1'b0, dvs});

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(DW - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // data
  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      work <= {work[DW-2:0], fits};
      rem  <= fits ? VW'(rem_sh - {1'b0, dvs}) : VW'(rem_sh);
    end
  end

  assign done     = !busy;
  assign quotient = work;
  assign rem_nz   = (rem != '0);

endmodule

// ----- rtl/mep_datapath.sv -----
// ----------------------------------------------------------------------------
// mep_datapath: coordinate mapping and escape-time iteration
// Maps the pixel to c through a multiplier and the shared divider, then runs
// z = z*z + c with registered products, and forms the pixel color.
// ----------------------------------------------------------------------------
module mep_datapath (
  input  logic                clk,
  input  logic                rst,
  input  mep_pkg::cfg_t       cfg,
  input  mep_pkg::coord_t     coord,
  input  mep_pkg::cmd_t       cmd,
  output mep_pkg::status_t    status,
  output mep_pkg::color_t     result
);

  localparam int CW    = mep_pkg::COORD_W;
  localparam int FB    = mep_pkg::FRAC_BITS;
  localparam int PW    = mep_pkg::PROD_W;
  localparam int DW    = mep_pkg::DIVIDEND_W;
  localparam int MAP_W = DW + 2;
  localparam int SQ_W  = PW - FB;        // floor(x*x / 2^F)
  localparam int RI_W  = SQ_W + 1;       // floor(x*y / 2^(F-1))
  localparam int ACC_W = RI_W + 1;

  localparam logic signed [MAP_W-1:0] C_MAX = MAP_W'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [MAP_W-1:0] C_MIN = ~C_MAX;
  localparam logic signed [ACC_W-1:0] LIM   =
    ACC_W'(64'(mep_pkg::ESC_LIMIT) << FB);

  // pixel and mapping state
  logic [mep_pkg::PIX_W-1:0]  col, row;
  logic [CW-1:0]              diff_mag;
  logic                       diff_neg;
  logic signed [CW:0]         diff;
  logic [mep_pkg::SIZE_W-1:0] size_sel, size_eff;
  logic                       div_start;
  logic [DW-1:0]              dividend;
  logic                       div_done;
  logic [DW-1:0]              quot;
  logic                       rem_nz;
  logic signed [MAP_W-1:0]    q_signed, map_sum;
  logic signed [CW-1:0]       lo_sel, map_sat;

  // iteration state
  logic signed [CW-1:0]       c_re, c_im, z_re, z_im;
  logic signed [PW-1:0]       p_rr, p_ii, p_ri;
  logic signed [SQ_W-1:0]     rr, ii;
  logic signed [RI_W-1:0]     ri;
  logic signed [ACC_W-1:0]    re_acc, im_acc, mag2;
  logic signed [CW-1:0]       re_next, im_next;
  logic [mep_pkg::ITER_W-1:0] n, n_inc;
  logic                       first;
  logic                       esc;

  mep_pkg::pal_entry_t        pal;

  // span of the selected axis
  assign diff = cmd.axis ? ((CW+1)'(cfg.bottom_im) - (CW+1)'(cfg.top_im))
                         : ((CW+1)'(cfg.right_re) - (CW+1)'(cfg.left_re));

  assign size_sel  = cmd.axis ? cfg.image_height : cfg.image_width;
  assign size_eff  = (size_sel == '0) ? mep_pkg::SIZE_W'(1) : size_sel;
  assign div_start = cmd.map_mul;
  assign dividend  = DW'(diff_mag) * DW'(cmd.axis ? row : col);

  mep_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (size_eff),
    .done     (div_done),
    .quotient (quot),
    .rem_nz   (rem_nz)
  );

  // floor of the signed quotient, offset, saturate to 32 bits
  assign q_signed = diff_neg ? (-MAP_W'(quot) - MAP_W'(rem_nz)) : MAP_W'(quot);
  assign lo_sel   = cmd.axis ? cfg.top_im : cfg.left_re;
  assign map_sum  = q_signed + MAP_W'(lo_sel);
  always_comb begin
    if (map_sum > C_MAX) begin
      map_sat = CW'(C_MAX);
    end else if (map_sum < C_MIN) begin
      map_sat = CW'(C_MIN);
    end else begin
      map_sat = CW'(map_sum);
    end
  end

  // one complex step from the registered products
  assign rr     = SQ_W'(p_rr >>> FB);
  assign ii     = SQ_W'(p_ii >>> FB);
  assign ri     = RI_W'(p_ri >>> (FB - 1));
  assign re_acc = ACC_W'(rr) - ACC_W'(ii) + ACC_W'(c_re);
  assign im_acc = ACC_W'(ri) + ACC_W'(c_im);
  assign mag2   = ACC_W'(rr) + ACC_W'(ii);
  assign esc    = (mag2 > LIM);
  assign n_inc  = n + 1'b1;

  always_comb begin
    if (re_acc > LIM) begin
      re_next = CW'(LIM);
    end else if (re_acc < -LIM) begin
      re_next = CW'(-LIM);
    end else begin
      re_next = CW'(re_acc);
    end
    if (im_acc > LIM) begin
      im_next = CW'(LIM);
    end else if (im_acc < -LIM) begin
      im_next = CW'(-LIM);
    end else begin
      im_next = CW'(im_acc);
    end
  end

  // pixel capture and mapping registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      col <= coord.pixel_col;
      row <= coord.pixel_row;
    end
    if (cmd.map_diff) begin
      diff_neg <= diff[CW];
      diff_mag <= CW'(diff[CW] ? -diff : diff);
    end
  end

  // c, z, products and step count
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      n     <= '0;
      first <= 1'b1;
    end
    if (cmd.map_fix) begin
      if (cmd.axis) begin
        c_im <= map_sat;
        z_im <= map_sat;
      end else begin
        c_re <= map_sat;
        z_re <= map_sat;
      end
    end
    if (cmd.iter_mul) begin
      p_rr <= z_re * z_re;
      p_ii <= z_im * z_im;
      p_ri <= z_re * z_im;
    end
    if (cmd.iter_upd) begin
      first <= 1'b0;
      // squares of z are the escape test of the previous step
      if (!first && !esc) begin
        n <= n_inc;
      end
      if (!status.iter_stop) begin
        z_re <= re_next;
        z_im <= im_next;
      end
    end
  end

  assign status.div_done   = div_done;
  assign status.limit_zero = (cfg.max_iter == '0);
  assign status.iter_stop  = !first && (esc || (n_inc == cfg.max_iter));

  // color of the finished pixel
  assign pal = mep_pkg::pal_lookup(cfg.palette);
  always_comb begin
    result.iter_count = n;
    result.in_set     = (n == cfg.max_iter);
    if (!result.in_set && (cfg.palette < mep_pkg::PAL_W'(mep_pkg::PAL_ENTRIES))) begin
      result.red   = mep_pkg::shade(n, pal.r);
      result.green = mep_pkg::shade(n, pal.g);
      result.blue  = mep_pkg::shade(n, pal.b);
    end else begin
      result.red   = '0;
      result.green = '0;
      result.blue  = '0;
    end
  end

endmodule

// ----- rtl/mep_ctrl.sv -----
// ----------------------------------------------------------------------------
// mep_ctrl: sequencing state machine
// Steps through mapping of both axes, the iteration loop and the hand-off of
// the result to the output register.
// ----------------------------------------------------------------------------
module mep_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              coord_valid,
  input  logic              out_free,
  input  mep_pkg::status_t  status,
  output mep_pkg::cmd_t     cmd,
  output logic              coord_ready
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DIFF = 8'b0000_0010,
    S_MUL  = 8'b0000_0100,
    S_DIV  = 8'b0000_1000,
    S_FIX  = 8'b0001_0000,
    S_ZMUL = 8'b0010_0000,
    S_ZUPD = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   axis, axis_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis  <= 1'b0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next  = state;
    axis_next   = axis;
    cmd         = '0;
    coord_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        coord_ready = 1'b1;
        if (coord_valid) begin
          cmd.capture = 1'b1;
          axis_next   = 1'b0;
          state_next  = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.map_diff = 1'b1;
        state_next   = S_MUL;
      end
      S_MUL: begin
        cmd.map_mul = 1'b1;
        state_next  = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_FIX;
        end
      end
      S_FIX: begin
        cmd.map_fix = 1'b1;
        if (!axis) begin
          axis_next  = 1'b1;
          state_next = S_DIFF;
        end else if (status.limit_zero) begin
          state_next = S_DONE;
        end else begin
          state_next = S_ZMUL;
        end
      end
      S_ZMUL: begin
        cmd.iter_mul = 1'b1;
        state_next   = S_ZUPD;
      end
      S_ZUPD: begin
        cmd.iter_upd = 1'b1;
        state_next   = status.iter_stop ? S_DONE : S_ZMUL;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    cmd.axis = axis;
  end

endmodule

// ----- rtl/mandelbrot_escape_pixel.sv -----
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel: escape-time color of one pixel
//
//   channel   signals                          direction  payload
//   coord     coord_valid/coord_ready, coord    request    pixel_col, pixel_row
//   color     color_valid/color_ready, color    result     rgb, iter_count, in_set
//   config    cfg_we, cfg_index, cfg_data       write      8 window/limit regs
//
// One pixel at a time. Mapping runs the divider once per axis, then each
// complex step passes a product state and an update state, for up to
// max_iter + 1 steps, before the result is loaded into the output register.
// The next pixel is taken while a result waits in the output register.
// Reset is synchronous and restores the default view window; a stalled
// result holds the sequencer in its final state until the slot frees.
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              coord_valid,
  output logic                              coord_ready,
  input  mep_pkg::coord_t                   coord,
  output logic                              color_valid,
  input  logic                              color_ready,
  output mep_pkg::color_t                   color,
  input  logic                              cfg_we,
  input  logic [mep_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mep_pkg::COORD_W-1:0]       cfg_data
);

  mep_pkg::cfg_t     cfg;
  mep_pkg::cmd_t     cmd;
  mep_pkg::status_t  status;
  mep_pkg::color_t   result;
  logic              out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.left_re      <= mep_pkg::RST_LEFT_RE;
      cfg.right_re     <= mep_pkg::RST_RIGHT_RE;
      cfg.top_im       <= mep_pkg::RST_TOP_IM;
      cfg.bottom_im    <= mep_pkg::RST_BOTTOM_IM;
      cfg.image_width  <= mep_pkg::RST_WIDTH;
      cfg.image_height <= mep_pkg::RST_HEIGHT;
      cfg.max_iter     <= mep_pkg::RST_MAX_ITER;
      cfg.palette      <= mep_pkg::RST_PALETTE;
    end else if (cfg_we) begin
      unique case (mep_pkg::cfg_idx_t'(cfg_index))
        mep_pkg::CFG_LEFT_RE:      cfg.left_re      <= cfg_data;
        mep_pkg::CFG_RIGHT_RE:     cfg.right_re     <= cfg_data;
        mep_pkg::CFG_TOP_IM:       cfg.top_im       <= cfg_data;
        mep_pkg::CFG_BOTTOM_IM:    cfg.bottom_im    <= cfg_data;
        mep_pkg::CFG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data[mep_pkg::SIZE_W-1:0];
        mep_pkg::CFG_IMAGE_HEIGHT: cfg.image_height <= cfg_data[mep_pkg::SIZE_W-1:0];
        mep_pkg::CFG_MAX_ITER:     cfg.max_iter     <= cfg_data[mep_pkg::ITER_W-1:0];
        mep_pkg::CFG_PALETTE:      cfg.palette      <= cfg_data[mep_pkg::PAL_W-1:0];
        default: ;
      endcase
    end
  end

  mep_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .coord_valid (coord_valid),
    .out_free    (out_free),
    .status      (status),
    .cmd         (cmd),
    .coord_ready (coord_ready)
  );

  mep_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .coord  (coord),
    .cmd    (cmd),
    .status (status),
    .result (result)
  );

  // output register
  assign out_free = !color_valid || color_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_valid <= 1'b0;
    end else if (cmd.out_load) begin
      color_valid <= 1'b1;
    end else if (color_ready) begin
      color_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      color <= result;
    end
  end

endmodule

// ----- rtl/mep_checker.sv -----
// ----------------------------------------------------------------------------
// mep_checker: port-level checks for mandelbrot_escape_pixel
// Reset state, one pixel in flight, black pixels in the set, result hold.
// ----------------------------------------------------------------------------
module mep_checker (
  input logic             clk,
  input logic             rst,
  input logic             coord_valid,
  input logic             coord_ready,
  input logic             color_valid,
  input logic             color_ready,
  input mep_pkg::color_t  color
);

  // reset empties the output and opens the request side
  a_reset: assert property (@(posedge clk) rst |=> (!color_valid && coord_ready))
    else $error("reset did not clear result or open request side");

  // a taken request closes the request side while it is worked on
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (coord_valid && coord_ready) |=> !coord_ready)
    else $error("second request taken while one is in work");

  // points in the set are black
  a_in_set_black: assert property (@(posedge clk) disable iff (rst)
    (color_valid && color.in_set) |->
      (color.red == '0 && color.green == '0 && color.blue == '0))
    else $error("in-set pixel has a nonzero channel");

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (color_valid && !color_ready) |=> (color_valid && $stable(color)))
    else $error("stalled result dropped or changed");

endmodule

bind mandelbrot_escape_pixel mep_checker u_mep_checker (.*);

// ----- tb/mandelbrot_escape_pixel_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel_tb: self-checking bench for the escape pixel block
// Pixel requests come from a queue that a clocked driver drains at random.
// Each accepted request is scored by a fixed-point predictor with its own
// view window, and the resulting color goes into a queue. A monitor compares
// every color the block returns with the oldest entry in that queue. The run
// starts with directed pixels and then moves through random view windows,
// iteration limits, palettes and idle patterns.
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel_tb;
  import mep_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  localparam longint COORD_MIN = -(64'sd1 <<< (COORD_W - 1));
  localparam longint COORD_MAX = (64'sd1 <<< (COORD_W - 1)) - 64'sd1;
  localparam longint Z_LIMIT   = longint'(ESC_LIMIT) <<< FRAC_BITS;
  localparam logic [7:0] DIV10 = SHADE_D10;
  localparam logic [7:0] DIV20 = SHADE_D20;
  localparam logic [7:0] DIV30 = SHADE_D30;
  localparam int RANDOM_BATCHES = 29;
  localparam int BATCH_PIXELS   = 20;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         coord_valid = 1'b0;
  logic         coord_ready;
  coord_t       coord = '0;
  logic         color_valid;
  logic         color_ready = 1'b0;
  color_t       color;
  logic         cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_LEFT_RE;
  logic [COORD_W-1:0]   cfg_data = '0;

  coord_t pixel_queue[$];
  color_t pending_colors[$];
  cfg_t   view_cfg;
  color_t want_color;
  logic   coord_fired = 1'b0;
  logic   hold_send = 1'b0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     fail_count = 0;

  mandelbrot_escape_pixel DUT (
    .clk         (clk),
    .rst         (rst),
    .coord_valid (coord_valid),
    .coord_ready (coord_ready),
    .coord       (coord),
    .color_valid (color_valid),
    .color_ready (color_ready),
    .color       (color),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // floor(a*b / 2^sh) on the full-width product
  function automatic longint mul_floor(longint a, longint b, int sh);
    logic signed [127:0] wa, wb, p;
    wa = a;
    wb = b;
    p = (wa * wb) >>> sh;
    return p[63:0];
  endfunction

  // floor(pos * (hi - lo) / size) + lo, saturated to the coordinate range
  function automatic longint map_axis(logic [PIX_W-1:0] pos, logic signed [COORD_W-1:0] lo,
                                      logic signed [COORD_W-1:0] hi,
                                      logic [SIZE_W-1:0] size);
    longint lo_v, span, p, prod, q, d;
    lo_v = lo;
    span = hi;
    span = span - lo_v;
    d = size;
    if (d == 0) d = 1;   // zero size acts as one
    p = pos;
    prod = p * span;
    q = prod / d;
    if (prod < 0 && q * d != prod) q = q - 1;
    return clamp_to(q + lo_v, COORD_MIN, COORD_MAX);
  endfunction

  // red, green, blue divisors of one palette entry
  function automatic logic [23:0] shade_divisors(logic [PAL_W-1:0] pal);
    case (pal)
      4'd0:    return {DIV10, DIV20, DIV30};
      4'd1:    return {DIV10, DIV30, DIV20};
      4'd2:    return {DIV20, DIV10, DIV30};
      4'd3:    return {DIV30, DIV10, DIV20};
      4'd4:    return {DIV30, DIV20, DIV10};
      4'd5:    return {DIV20, DIV30, DIV10};
      4'd6:    return {DIV20, DIV30, DIV20};
      4'd7:    return {DIV30, DIV20, DIV20};
      4'd8:    return {DIV20, DIV20, DIV30};
      default: return {DIV30, DIV30, DIV10};
    endcase
  endfunction

  function automatic color_t predict_color(coord_t px);
    longint cre, cim, re, im, rr, ii, ri;
    int unsigned n;
    logic escaped;
    logic [23:0] divs;
    color_t c;
    cre = map_axis(px.pixel_col, view_cfg.left_re, view_cfg.right_re, view_cfg.image_width);
    cim = map_axis(px.pixel_row, view_cfg.top_im, view_cfg.bottom_im, view_cfg.image_height);
    re = cre;
    im = cim;
    n = 0;
    escaped = 1'b0;
    // z = z*z + c until |z|^2 > 4 or the limit is reached
    while (n < view_cfg.max_iter && !escaped) begin
      rr = mul_floor(re, re, FRAC_BITS);
      ii = mul_floor(im, im, FRAC_BITS);
      ri = mul_floor(re, im, FRAC_BITS - 1);
      re = clamp_to(rr - ii + cre, -Z_LIMIT, Z_LIMIT);
      im = clamp_to(ri + cim, -Z_LIMIT, Z_LIMIT);
      if (mul_floor(re, re, FRAC_BITS) + mul_floor(im, im, FRAC_BITS) > Z_LIMIT)
        escaped = 1'b1;
      else
        n++;
    end
    c = '0;
    // escaped pixels are shaded; unknown palettes stay black
    if (n < view_cfg.max_iter && view_cfg.palette < PAL_ENTRIES) begin
      divs = shade_divisors(view_cfg.palette);
      c.red   = 8'(n * CHAN_MAX / divs[23:16]);
      c.green = 8'(n * CHAN_MAX / divs[15:8]);
      c.blue  = 8'(n * CHAN_MAX / divs[7:0]);
    end
    c.iter_count = n[ITER_W-1:0];
    c.in_set = (n == view_cfg.max_iter);
    return c;
  endfunction

  // ------------------------------------------------------------------ driver

  // new request only once the previous one is taken
  always @(negedge clk) begin
    if (rst) begin
      coord_valid <= 1'b0;
    end else if (!coord_valid || coord_fired) begin
      if (!hold_send && pixel_queue.size() != 0 &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        coord <= pixel_queue.pop_front();
        coord_valid <= 1'b1;
      end else begin
        coord_valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    color_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // ----------------------------------------------------------------- monitor

  always @(posedge clk) begin
    coord_fired <= !rst && coord_valid && coord_ready;
    if (!rst) begin
      if (color_valid && color_ready) begin
        if (pending_colors.size() == 0) begin
          $display("%0t: unexpected color r=%0d g=%0d b=%0d iter=%0d in_set=%0d", $time,
                   color.red, color.green, color.blue, color.iter_count, color.in_set);
          fail_count++;
        end else begin
          want_color = pending_colors.pop_front();
          if (want_color.red !== color.red || want_color.green !== color.green ||
              want_color.blue !== color.blue || want_color.iter_count !== color.iter_count ||
              want_color.in_set !== color.in_set) begin
            $display("%0t: color mismatch expected r=%0d g=%0d b=%0d iter=%0d in_set=%0d",
                     $time, want_color.red, want_color.green, want_color.blue,
                     want_color.iter_count, want_color.in_set);
            $display("%0t:                  actual r=%0d g=%0d b=%0d iter=%0d in_set=%0d",
                     $time, color.red, color.green, color.blue, color.iter_count,
                     color.in_set);
            fail_count++;
          end
        end
      end
      if (coord_valid && coord_ready) pending_colors.push_back(predict_color(coord));
    end
  end

  // --------------------------------------------------------------- stimulus

  task automatic queue_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
    coord_t px;
    px.pixel_col = col;
    px.pixel_row = row;
    pixel_queue.push_back(px);
  endtask

  // block is idle: nothing queued, in flight or outstanding
  task automatic wait_idle();
    while (pixel_queue.size() != 0 || coord_valid || pending_colors.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [COORD_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_LEFT_RE:      view_cfg.left_re = val;
      CFG_RIGHT_RE:     view_cfg.right_re = val;
      CFG_TOP_IM:       view_cfg.top_im = val;
      CFG_BOTTOM_IM:    view_cfg.bottom_im = val;
      CFG_IMAGE_WIDTH:  view_cfg.image_width = val[SIZE_W-1:0];
      CFG_IMAGE_HEIGHT: view_cfg.image_height = val[SIZE_W-1:0];
      CFG_MAX_ITER:     view_cfg.max_iter = val[ITER_W-1:0];
      CFG_PALETTE:      view_cfg.palette = val[PAL_W-1:0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_view(input logic signed [COORD_W-1:0] lft, rgt, tp, bt,
                          input logic [SIZE_W-1:0] w, h,
                          input logic [ITER_W-1:0] limit,
                          input logic [PAL_W-1:0] pal);
    write_reg(CFG_LEFT_RE, lft);
    write_reg(CFG_RIGHT_RE, rgt);
    write_reg(CFG_TOP_IM, tp);
    write_reg(CFG_BOTTOM_IM, bt);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_MAX_ITER, limit);
    write_reg(CFG_PALETTE, pal);
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 19))
      0:       return 13'd0;
      1:       return 13'd1;
      2:       return 13'd4096;
      default: return 13'($urandom_range(1, 4096));
    endcase
  endfunction

  // mostly inside the image, sometimes any 12-bit position
  function automatic logic [PIX_W-1:0] pick_pos(logic [SIZE_W-1:0] size);
    if (size != 0 && $urandom_range(0, 9) < 8)
      return PIX_W'($urandom_range(0, size - 1));
    return PIX_W'($urandom);
  endfunction

  task automatic random_view();
    int kind, r;
    int half, ctr_re, ctr_im;
    logic signed [COORD_W-1:0] lft, rgt, tp, bt;
    logic [ITER_W-1:0] limit;
    logic [PAL_W-1:0] pal;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      // wide window: left -2.5..-1.5, right 0.25..1.0, imaginary +-0.8..1.5
      lft = -$urandom_range(402653184, 671088640);
      rgt = $urandom_range(67108864, 268435456);
      tp  = -$urandom_range(214748365, 402653184);
      bt  = $urandom_range(214748365, 402653184);
    end else if (kind < 8) begin
      // zoom near the boundary around -0.75 + 0.1i
      half = 1 << $urandom_range(10, 24);
      ctr_re = -201326592 + int'($urandom_range(0, 60000000)) - 30000000;
      ctr_im = 26843546 + int'($urandom_range(0, 60000000)) - 30000000;
      lft = ctr_re - half;
      rgt = ctr_re + half;
      tp  = ctr_im - half;
      bt  = ctr_im + half;
    end else begin
      lft = $urandom;
      rgt = $urandom;
      tp  = $urandom;
      bt  = $urandom;
    end
    r = $urandom_range(0, 19);
    if (r == 0)      limit = 10'd1000;
    else if (r == 1) limit = 10'($urandom_range(200, 999));
    else if (r == 2) limit = 10'd1;
    else             limit = 10'($urandom_range(2, 40));
    pal = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
    set_view(lft, rgt, tp, bt, pick_size(), pick_size(), limit, pal);
  endtask

  initial begin
    view_cfg.left_re      = RST_LEFT_RE;
    view_cfg.right_re     = RST_RIGHT_RE;
    view_cfg.top_im       = RST_TOP_IM;
    view_cfg.bottom_im    = RST_BOTTOM_IM;
    view_cfg.image_width  = RST_WIDTH;
    view_cfg.image_height = RST_HEIGHT;
    view_cfg.max_iter     = RST_MAX_ITER;
    view_cfg.palette      = RST_PALETTE;
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    @(posedge clk);

    // default window: corners, middle, beyond the image size
    queue_pixel(12'd0, 12'd0);
    queue_pixel(12'd4095, 12'd4095);
    queue_pixel(12'd1023, 12'd767);
    queue_pixel(12'd512, 12'd384);
    queue_pixel(12'd700, 12'd300);
    wait_idle();

    // widest window, zero width, palette beyond nine, saturated mapping
    set_view(32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000,
             13'd0, 13'd1, 10'd1, 4'd15);
    queue_pixel(12'd0, 12'd0);
    queue_pixel(12'd4095, 12'd0);
    queue_pixel(12'd4095, 12'd4095);
    queue_pixel(12'd1, 12'd1);
    wait_idle();

    // zero iteration limit
    write_reg(CFG_MAX_ITER, 10'd0);
    queue_pixel(12'd0, 12'd0);
    queue_pixel(12'd100, 12'd200);
    wait_idle();

    // tiny window at the origin, limit of 1000: points in the set
    set_view(-65536, 65536, -65536, 65536, 13'd4096, 13'd4096, 10'd1000, 4'd9);
    queue_pixel(12'd2048, 12'd2048);
    queue_pixel(12'd0, 12'd4095);
    queue_pixel(12'd4095, 12'd4095);
    wait_idle();

    // random windows, rotating through the idle patterns
    for (int batch = 0; batch < RANDOM_BATCHES; batch++) begin
      case (idle_mode_t'(batch % 4))
        IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        IDLE_SENDER:   begin send_idle_pct = 75; recv_stall_pct = 0;  end
        IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        IDLE_BOTH:     begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      random_view();
      repeat (BATCH_PIXELS)
        queue_pixel(pick_pos(view_cfg.image_width), pick_pos(view_cfg.image_height));
      // once: stop sending mid-batch until every color is back
      if (batch == RANDOM_BATCHES / 2) begin
        while (pixel_queue.size() > BATCH_PIXELS / 2) @(posedge clk);
        hold_send = 1'b1;
        while (coord_valid || pending_colors.size() != 0) @(posedge clk);
        repeat ($urandom_range(1, 30)) @(posedge clk);
        hold_send = 1'b0;
      end
      wait_idle();
    end

    // room for a stray result after the last one
    repeat (2200) @(posedge clk);
    if (pending_colors.size() != 0) fail_count++;
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // watchdog
  initial begin
    #(50_000_000);
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- mandelbrot_escape_pixel.f -----
rtl/mep_pkg.sv
rtl/mep_div.sv
rtl/mep_datapath.sv
rtl/mep_ctrl.sv
rtl/mandelbrot_escape_pixel.sv
rtl/mep_checker.sv
tb/mandelbrot_escape_pixel_tb.sv
